/* sv/bof_pkg.sv */
// bof_pkg: shared types and constants of the bezier outline flattener
// holds register indexes, command codes, the configuration bundle and the vertex record
// no dependencies
package bof_pkg;

  localparam int MODE_W     = 2;
  localparam int STEP_W     = 7;
  localparam int DELTA_W    = 25;
  localparam int SCALE_W    = 16;
  localparam int ACC_W      = 64;
  localparam int NUM_W      = 16;
  localparam int VERT_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int DELTA_FRAC = 24;
  localparam int OUT_SHIFT  = 30;
  localparam int OUT_DATA_W = 2 * VERT_W + NUM_W;

  localparam logic [STEP_W-1:0]  STEP_COUNT_RST   = 7'd16;
  localparam logic [DELTA_W-1:0] DELTA_LINEAR_RST = 25'd1048576;
  localparam logic [DELTA_W-1:0] DELTA_SQUARE_RST = 25'd65536;
  localparam logic [DELTA_W-1:0] DELTA_CUBE_RST   = 25'd4096;
  localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST = 16'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COUNT   = 3'd0,
    REG_DELTA_LINEAR = 3'd1,
    REG_DELTA_SQUARE = 3'd2,
    REG_DELTA_CUBE   = 3'd3,
    REG_OUTPUT_SCALE = 3'd4
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_QUAD  = 2'd2,
    MODE_CUBIC = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MUL_C = 2'd0,
    MUL_B = 2'd1,
    MUL_A = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_C    = 2'd1,
    ACC_B    = 2'd2,
    ACC_A    = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_count;
    logic [DELTA_W-1:0] delta_linear;
    logic [DELTA_W-1:0] delta_square;
    logic [DELTA_W-1:0] delta_cube;
    logic [SCALE_W-1:0] output_scale;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     do_move;
    logic     coef_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     push_inner;
    logic     push_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACC_W-1:0] fx;
    logic [ACC_W-1:0] fy;
    logic [NUM_W-1:0] number;
    logic             first;
    logic             last;
  } vtx_t;

endpackage

/* sv/bof_cfg.sv */
// bof_cfg: configuration register file of the flattener
// depends on bof_pkg
module bof_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bof_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bof_pkg::CFG_DATA_W-1:0] cfg_data,
  output bof_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count   <= bof_pkg::STEP_COUNT_RST;
      cfg.delta_linear <= bof_pkg::DELTA_LINEAR_RST;
      cfg.delta_square <= bof_pkg::DELTA_SQUARE_RST;
      cfg.delta_cube   <= bof_pkg::DELTA_CUBE_RST;
      cfg.output_scale <= bof_pkg::OUTPUT_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (bof_pkg::cfg_reg_t'(cfg_index))
        bof_pkg::REG_STEP_COUNT: begin
          cfg.step_count <= cfg_data[bof_pkg::STEP_W-1:0];
        end
        bof_pkg::REG_DELTA_LINEAR: begin
          cfg.delta_linear <= cfg_data[bof_pkg::DELTA_W-1:0];
        end
        bof_pkg::REG_DELTA_SQUARE: begin
          cfg.delta_square <= cfg_data[bof_pkg::DELTA_W-1:0];
        end
        bof_pkg::REG_DELTA_CUBE: begin
          cfg.delta_cube <= cfg_data[bof_pkg::DELTA_W-1:0];
        end
        bof_pkg::REG_OUTPUT_SCALE: begin
          cfg.output_scale <= cfg_data[bof_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/bof_ctrl.sv */
// bof_ctrl: command sequencer of the flattener
// walks moves, lines, curve setup, forward-difference stepping and end point; depends on bof_pkg
module bof_ctrl #(
  parameter int MAX_STEPS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic [bof_pkg::MODE_W-1:0]  s_mode,
  input  logic [bof_pkg::STEP_W-1:0]  step_count,
  input  logic                        push_ready,
  output bof_pkg::dp_cmd_t            cmd
);

  localparam int CNT_W = $clog2(MAX_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_COEF = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_MFIN = 6'b001000,
    ST_STEP = 6'b010000,
    ST_LAST = 6'b100000
  } state_t;

  state_t                     state, state_next;
  logic [CNT_W-1:0]           cnt, cnt_next;
  logic [1:0]                 mcnt, mcnt_next;
  logic [bof_pkg::STEP_W-1:0] steps_eff;
  logic [bof_pkg::STEP_W-1:0] inner_steps;
  logic                       accept;

  // zero steps acts as one, large counts clip to the build limit
  always_comb begin
    if (step_count == '0) begin
      steps_eff = bof_pkg::STEP_W'(1);
    end else if (step_count > bof_pkg::STEP_W'(MAX_STEPS)) begin
      steps_eff = bof_pkg::STEP_W'(MAX_STEPS);
    end else begin
      steps_eff = step_count;
    end
  end

  assign inner_steps = steps_eff - bof_pkg::STEP_W'(1);
  assign s_ready     = (state == ST_IDLE);
  assign accept      = s_valid && s_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    mcnt_next  = mcnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          if (s_mode == bof_pkg::MODE_MOVE) begin
            cmd.do_move = 1'b1;
          end else if (s_mode == bof_pkg::MODE_LINE) begin
            state_next = ST_LAST;
          end else begin
            state_next = ST_COEF;
          end
        end
      end
      ST_COEF: begin
        cmd.coef_load = 1'b1;
        cnt_next      = inner_steps[CNT_W-1:0];
        mcnt_next     = 2'd0;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        // product of the previous cycle is folded in while the next one is formed
        cmd.mul_en = 1'b1;
        case (mcnt)
          2'd0: begin
            cmd.mul_sel = bof_pkg::MUL_C;
            cmd.acc_op  = bof_pkg::ACC_NONE;
          end
          2'd1: begin
            cmd.mul_sel = bof_pkg::MUL_B;
            cmd.acc_op  = bof_pkg::ACC_C;
          end
          default: begin
            cmd.mul_sel = bof_pkg::MUL_A;
            cmd.acc_op  = bof_pkg::ACC_B;
          end
        endcase
        mcnt_next = mcnt + 2'd1;
        if (mcnt == 2'd2) begin
          state_next = ST_MFIN;
        end
      end
      ST_MFIN: begin
        cmd.acc_op = bof_pkg::ACC_A;
        state_next = (cnt == '0) ? ST_LAST : ST_STEP;
      end
      ST_STEP: begin
        if (push_ready) begin
          cmd.push_inner = 1'b1;
          cnt_next       = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state_next = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        if (push_ready) begin
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      mcnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      mcnt  <= mcnt_next;
    end
  end

endmodule

/* sv/bof_dp.sv */
// bof_dp: datapath of the flattener
// pen, curve coefficients, shared delta multipliers and forward-difference accumulators
// depends on bof_pkg
module bof_dp #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bof_pkg::dp_cmd_t             cmd,
  input  bof_pkg::cfg_t                cfg,
  input  logic [bof_pkg::MODE_W-1:0]   in_mode,
  input  logic [6*COORD_BITS-1:0]      in_pts,
  output logic                         vtx_valid,
  output bof_pkg::vtx_t                vtx
);

  localparam int CB     = COORD_BITS;
  localparam int COEF_W = CB + 4;
  localparam int MUL_W  = bof_pkg::DELTA_W + 1;
  localparam int PROD_W = COEF_W + MUL_W;
  localparam int ACC_W  = bof_pkg::ACC_W;

  logic signed [CB-1:0] ex, ey, c1x, c1y, c2x, c2y;
  logic signed [CB-1:0] pen_x, pen_y;
  logic                 cubic;
  logic [bof_pkg::NUM_W-1:0] vertex_counter;
  logic                 contour_open_mark;

  logic signed [COEF_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [COEF_W-1:0] opx, opy;
  logic [bof_pkg::DELTA_W-1:0] dsel;
  logic signed [MUL_W-1:0]  dsg;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic [ACC_W-1:0] px, py;
  logic [ACC_W-1:0] fx, fy, dfx, dfy, d2x, d2y, d3x, d3y;
  logic [ACC_W-1:0] endx, endy;

  function automatic logic signed [COEF_W-1:0] coef_a(
    input logic signed [COEF_W-1:0] p, c1, c2, e, input logic is_cubic);
    logic signed [COEF_W-1:0] r;
    r = e - p + (c1 <<< 1) + c1 - (c2 <<< 1) - c2;
    return is_cubic ? r : '0;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_b(
    input logic signed [COEF_W-1:0] p, c1, c2, e, input logic is_cubic);
    logic signed [COEF_W-1:0] r;
    if (is_cubic) begin
      r = (p <<< 1) + p - (c1 <<< 2) - (c1 <<< 1) + (c2 <<< 1) + c2;
    end else begin
      r = p - (c1 <<< 1) + e;
    end
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_c(
    input logic signed [COEF_W-1:0] p, c1, input logic is_cubic);
    logic signed [COEF_W-1:0] d;
    d = c1 - p;
    return is_cubic ? (d <<< 1) + d : (d <<< 1);
  endfunction

  // captured command and pen state
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ex    <= in_pts[0*CB +: CB];
      ey    <= in_pts[1*CB +: CB];
      c1x   <= in_pts[2*CB +: CB];
      c1y   <= in_pts[3*CB +: CB];
      c2x   <= in_pts[4*CB +: CB];
      c2y   <= in_pts[5*CB +: CB];
      cubic <= (in_mode == bof_pkg::MODE_CUBIC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x             <= '0;
      pen_y             <= '0;
      vertex_counter    <= '0;
      contour_open_mark <= 1'b0;
    end else begin
      if (cmd.do_move) begin
        pen_x             <= in_pts[0*CB +: CB];
        pen_y             <= in_pts[1*CB +: CB];
        contour_open_mark <= 1'b1;
      end else if (vtx_valid) begin
        contour_open_mark <= 1'b0;
      end
      if (vtx_valid) begin
        vertex_counter <= vertex_counter + bof_pkg::NUM_W'(1);
      end
      if (cmd.push_last) begin
        pen_x <= ex;
        pen_y <= ey;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_load) begin
      ax <= coef_a(COEF_W'(pen_x), COEF_W'(c1x), COEF_W'(c2x), COEF_W'(ex), cubic);
      ay <= coef_a(COEF_W'(pen_y), COEF_W'(c1y), COEF_W'(c2y), COEF_W'(ey), cubic);
      bx <= coef_b(COEF_W'(pen_x), COEF_W'(c1x), COEF_W'(c2x), COEF_W'(ex), cubic);
      by <= coef_b(COEF_W'(pen_y), COEF_W'(c1y), COEF_W'(c2y), COEF_W'(ey), cubic);
      cx <= coef_c(COEF_W'(pen_x), COEF_W'(c1x), cubic);
      cy <= coef_c(COEF_W'(pen_y), COEF_W'(c1y), cubic);
    end
  end

  // one multiplier per axis, shared over the three delta products
  always_comb begin
    case (cmd.mul_sel)
      bof_pkg::MUL_C: begin
        opx  = cx;
        opy  = cy;
        dsel = cfg.delta_linear;
      end
      bof_pkg::MUL_B: begin
        opx  = bx;
        opy  = by;
        dsel = cfg.delta_square;
      end
      default: begin
        opx  = ax;
        opy  = ay;
        dsel = cfg.delta_cube;
      end
    endcase
  end

  assign dsg = {1'b0, dsel};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_x <= opx * dsg;
      prod_y <= opy * dsg;
    end
  end

  assign px = ACC_W'(prod_x);
  assign py = ACC_W'(prod_y);

  // accumulators wrap at the full accumulator width
  always_ff @(posedge clk) begin
    if (cmd.push_inner) begin
      fx  <= fx + dfx;
      fy  <= fy + dfy;
      dfx <= dfx + d2x;
      dfy <= dfy + d2y;
      d2x <= d2x + d3x;
      d2y <= d2y + d3y;
    end else begin
      case (cmd.acc_op)
        bof_pkg::ACC_C: begin
          fx  <= ACC_W'(pen_x) << bof_pkg::DELTA_FRAC;
          fy  <= ACC_W'(pen_y) << bof_pkg::DELTA_FRAC;
          dfx <= px;
          dfy <= py;
          d2x <= '0;
          d2y <= '0;
          d3x <= '0;
          d3y <= '0;
        end
        bof_pkg::ACC_B: begin
          dfx <= dfx + px;
          dfy <= dfy + py;
          d2x <= px << 1;
          d2y <= py << 1;
        end
        bof_pkg::ACC_A: begin
          dfx <= dfx + px;
          dfy <= dfy + py;
          d2x <= d2x + (px << 2) + (px << 1);
          d2y <= d2y + (py << 2) + (py << 1);
          d3x <= (px << 2) + (px << 1);
          d3y <= (py << 2) + (py << 1);
        end
        default: begin
        end
      endcase
    end
  end

  assign endx = ACC_W'(ex) << bof_pkg::DELTA_FRAC;
  assign endy = ACC_W'(ey) << bof_pkg::DELTA_FRAC;

  assign vtx_valid  = cmd.push_inner || cmd.push_last;
  assign vtx.fx     = cmd.push_last ? endx : fx + dfx;
  assign vtx.fy     = cmd.push_last ? endy : fy + dfy;
  assign vtx.number = vertex_counter;
  assign vtx.first  = contour_open_mark;
  assign vtx.last   = cmd.push_last;

endmodule

/* sv/bof_out.sv */
// bof_out: vertex scaling and output pipeline
// capture, scale multiply, floor and saturate, output register; depends on bof_pkg
module bof_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bof_pkg::SCALE_W-1:0] scale,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bof_pkg::vtx_t               in_vtx,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bof_pkg::VERT_W-1:0]  out_x,
  output logic [bof_pkg::VERT_W-1:0]  out_y,
  output logic [bof_pkg::NUM_W-1:0]   out_num,
  output logic                        out_first,
  output logic                        out_last
);

  localparam int HALF_W = bof_pkg::ACC_W / 2;
  localparam int HI_W   = HALF_W + bof_pkg::SCALE_W + 1;
  localparam int LO_W   = HALF_W + bof_pkg::SCALE_W;
  localparam int R_W    = HI_W + 2;
  localparam int VW     = bof_pkg::VERT_W;

  bof_pkg::vtx_t p_vtx;
  logic          p_valid, m_valid;
  logic          p_ready, m_ready, o_ready;
  logic signed [HI_W-1:0]    m_hx, m_hy;
  logic [LO_W-1:0]           m_lx, m_ly;
  logic [bof_pkg::NUM_W-1:0] m_num;
  logic                      m_first, m_last;
  logic signed [bof_pkg::SCALE_W:0] scale_s;

  // upper half times scale, plus the integer part of the lower half product,
  // gives the floor; then clamp to the signed vertex range
  function automatic logic [VW-1:0] sat_out(input logic signed [HI_W-1:0] hi,
                                            input logic [LO_W-1:0] lo);
    logic [R_W-1:0] r;
    logic [VW-1:0]  res;
    r = (R_W'(hi) <<< 2) + R_W'(lo[LO_W-1:bof_pkg::OUT_SHIFT]);
    if ((r[R_W-1:VW-1] == '0) || (&r[R_W-1:VW-1])) begin
      res = r[VW-1:0];
    end else if (r[R_W-1]) begin
      res = {1'b1, {(VW-1){1'b0}}};
    end else begin
      res = {1'b0, {(VW-1){1'b1}}};
    end
    return res;
  endfunction

  assign scale_s  = {1'b0, scale};
  assign o_ready  = !out_valid || out_ready;
  assign m_ready  = !m_valid || o_ready;
  assign p_ready  = !p_valid || m_ready;
  assign in_ready = p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= in_valid;
      end
      if (m_ready) begin
        m_valid <= p_valid;
      end
      if (o_ready) begin
        out_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      p_vtx <= in_vtx;
    end
    if (m_ready && p_valid) begin
      m_hx    <= $signed(p_vtx.fx[bof_pkg::ACC_W-1:HALF_W]) * scale_s;
      m_hy    <= $signed(p_vtx.fy[bof_pkg::ACC_W-1:HALF_W]) * scale_s;
      m_lx    <= p_vtx.fx[HALF_W-1:0] * scale;
      m_ly    <= p_vtx.fy[HALF_W-1:0] * scale;
      m_num   <= p_vtx.number;
      m_first <= p_vtx.first;
      m_last  <= p_vtx.last;
    end
    if (o_ready && m_valid) begin
      out_x     <= sat_out(m_hx, m_lx);
      out_y     <= sat_out(m_hy, m_ly);
      out_num   <= m_num;
      out_first <= m_first;
      out_last  <= m_last;
    end
  end

endmodule

/* sv/bezier_outline_flattener.sv */
// bezier_outline_flattener: top level of the outline flattener
// depends on bof_pkg, bof_cfg, bof_ctrl, bof_dp, bof_out
//
// Usage:
//   s_axis carries one outline command per transaction: tuser is the mode
//   (move, line, quadratic, cubic), tdata the end point and the two control
//   points in signed 18.6. m_axis carries the vertices: tdata holds the scaled
//   x, y and the running vertex number, tuser marks the first vertex after a
//   move, tlast the last vertex of each command. cfg writes a register by
//   index; the user must write only while the block is idle, which the
//   block itself does not enforce; cfg is always ready. A move gives
//   no vertex and a line gives one. A curve of n steps first runs its setup
//   (coefficients, three shared delta products per axis, final fold), then
//   gives one vertex per cycle while the output accepts, from the difference
//   accumulators and the end point; a new command is taken only after the
//   end point has been pushed. Vertices then pass the three-stage scaling
//   pipeline. Reset restores the register defaults, clears the pen, the
//   vertex number and the contour mark. A stalled receiver fills the output
//   pipeline and then holds the stepping until a slot frees.
module bezier_outline_flattener #(
  parameter int MAX_STEPS  = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // end_x, end_y, first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic [bof_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // vertex_x, vertex_y, vertex_number
  output logic [bof_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // contour_first
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bof_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bof_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bof_pkg::cfg_t    cfg;
  bof_pkg::dp_cmd_t cmd;
  bof_pkg::vtx_t    vtx;
  logic             vtx_valid;
  logic             push_ready;
  logic [bof_pkg::VERT_W-1:0] out_x, out_y;
  logic [bof_pkg::NUM_W-1:0]  out_num;

  bof_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bof_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_mode     (s_axis_tuser),
    .step_count (cfg.step_count),
    .push_ready (push_ready),
    .cmd        (cmd)
  );

  bof_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_mode   (s_axis_tuser),
    .in_pts    (s_axis_tdata[6*COORD_BITS-1:0]),
    .vtx_valid (vtx_valid),
    .vtx       (vtx)
  );

  bof_out u_out (
    .clk       (clk),
    .rst       (rst),
    .scale     (cfg.output_scale),
    .in_valid  (vtx_valid),
    .in_ready  (push_ready),
    .in_vtx    (vtx),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_num   (out_num),
    .out_first (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_num, out_y, out_x};

endmodule

/* sv/bof_checker.sv */
// bof_checker: port-level assertions for the outline flattener
// bound to bezier_outline_flattener; depends on bof_pkg
module bof_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic [bof_pkg::MODE_W-1:0]       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bof_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [bof_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [bof_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bof_pkg::NUM_W-1:0] last_num;
  logic                      have_num;
  logic                      prev_last;
  logic                      out_xfer;
  logic [bof_pkg::NUM_W-1:0] out_num;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_num  = m_axis_tdata[2*bof_pkg::VERT_W +: bof_pkg::NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      have_num  <= 1'b0;
      prev_last <= 1'b1;
    end else if (out_xfer) begin
      have_num  <= 1'b1;
      last_num  <= out_num;
      prev_last <= m_axis_tlast;
    end
  end

  // a stalled vertex stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("vertex changed while stalled");

  // vertex numbers run on by one per transaction
  a_num_seq: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && have_num) |-> (out_num == last_num + bof_pkg::NUM_W'(1)))
    else $error("vertex number skipped");

  // a contour only opens once the previous command has finished its run
  a_first_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_axis_tuser) |-> prev_last)
    else $error("contour opened inside a run");

  // a drawing command keeps the input closed for the following cycle
  a_busy_after_draw: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != bof_pkg::MODE_MOVE)) |=>
      !s_axis_tready)
    else $error("input reopened during a command");

endmodule

bind bezier_outline_flattener bof_checker #(.COORD_BITS(COORD_BITS)) u_bof_checker (.*);

/* tb/bezier_outline_flattener_test.sv */
// bezier_outline_flattener_test: self-checking bench for the outline flattener
// predicts every vertex from the accepted commands and compares the m_axis stream
// depends on bof_pkg and bezier_outline_flattener
`timescale 1ns / 1ps

module bezier_outline_flattener_test;

  localparam int  COORD_W     = 24;
  localparam int  IN_DATA_W   = ((6 * COORD_W + 7) / 8) * 8;
  localparam int  CFG_W       = bof_pkg::CFG_DATA_W;
  localparam int  STEP_LIMIT  = 64;
  localparam int  IDLE_LIMIT  = 3000;
  localparam int  LONG_HOLD   = 300;
  localparam int  SETTLE      = 40;
  localparam int  PHASES      = 8;
  localparam int  PHASE_ITEMS = 60;
  localparam logic [bof_pkg::CFG_IDX_W-1:0] UNUSED_REG = 3'd7;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;

  typedef struct {
    bof_pkg::mode_t            mode;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] c1x;
    logic signed [COORD_W-1:0] c1y;
    logic signed [COORD_W-1:0] c2x;
    logic signed [COORD_W-1:0] c2y;
  } outline_cmd_t;

  typedef struct {
    logic signed [bof_pkg::VERT_W-1:0] x;
    logic signed [bof_pkg::VERT_W-1:0] y;
    logic [bof_pkg::NUM_W-1:0]         number;
    logic                              first;
    logic                              last;
  } vertex_rec_t;

  class outline_tracker;
    logic [bof_pkg::STEP_W-1:0]  step_count;
    logic [bof_pkg::DELTA_W-1:0] delta_linear;
    logic [bof_pkg::DELTA_W-1:0] delta_square;
    logic [bof_pkg::DELTA_W-1:0] delta_cube;
    logic [bof_pkg::SCALE_W-1:0] output_scale;
    longint                      pen_x;
    longint                      pen_y;
    logic [bof_pkg::NUM_W-1:0]   vertex_count;
    logic                        contour_open;
    vertex_rec_t                 expected_vertices[$];
    int                          errors;

    function new();
      step_count   = bof_pkg::STEP_COUNT_RST;
      delta_linear = bof_pkg::DELTA_LINEAR_RST;
      delta_square = bof_pkg::DELTA_SQUARE_RST;
      delta_cube   = bof_pkg::DELTA_CUBE_RST;
      output_scale = bof_pkg::OUTPUT_SCALE_RST;
      pen_x        = 0;
      pen_y        = 0;
      vertex_count = '0;
      contour_open = 1'b0;
      errors       = 0;
    endfunction

    function void note_register(logic [bof_pkg::CFG_IDX_W-1:0] index,
                                logic [bof_pkg::CFG_DATA_W-1:0] value);
      case (index)
        bof_pkg::REG_STEP_COUNT:   step_count   = value[bof_pkg::STEP_W-1:0];
        bof_pkg::REG_DELTA_LINEAR: delta_linear = value[bof_pkg::DELTA_W-1:0];
        bof_pkg::REG_DELTA_SQUARE: delta_square = value[bof_pkg::DELTA_W-1:0];
        bof_pkg::REG_DELTA_CUBE:   delta_cube   = value[bof_pkg::DELTA_W-1:0];
        bof_pkg::REG_OUTPUT_SCALE: output_scale = value[bof_pkg::SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(f * scale / 2^30) of a signed Q40.24 accumulator, saturated to 32 bits
    function logic signed [bof_pkg::VERT_W-1:0] scale_to_vertex(
      logic [bof_pkg::ACC_W-1:0] f);
      logic signed [81:0] wide;
      logic signed [81:0] sc;
      logic signed [81:0] hi_lim;
      logic signed [81:0] lo_lim;
      hi_lim = 82'sd2147483647;
      lo_lim = -82'sd2147483648;
      wide   = $signed(f);
      sc     = output_scale;
      wide   = (wide * sc) >>> bof_pkg::OUT_SHIFT;
      if (wide > hi_lim) return 32'sh7fffffff;
      if (wide < lo_lim) return 32'sh80000000;
      return wide[bof_pkg::VERT_W-1:0];
    endfunction

    function void add_vertex(logic [bof_pkg::ACC_W-1:0] fx, logic [bof_pkg::ACC_W-1:0] fy,
                             logic last);
      vertex_rec_t v;
      v.x      = scale_to_vertex(fx);
      v.y      = scale_to_vertex(fy);
      v.number = vertex_count;
      v.first  = contour_open;
      v.last   = last;
      expected_vertices = {expected_vertices, v};
      vertex_count = vertex_count + 1'b1;
      contour_open = 1'b0;
    endfunction

    function void note_command(outline_cmd_t c);
      longint ex, ey, c1x, c1y, c2x, c2y;
      longint ax, ay, bx, by, cx, cy, d1, d2, d3, q24_one;
      logic [bof_pkg::ACC_W-1:0] fx, fy, dfx, dfy, ddx, ddy, dddx, dddy;
      int n;
      int i;
      q24_one = 64'sd16777216;
      ex  = c.ex;
      ey  = c.ey;
      c1x = c.c1x;
      c1y = c.c1y;
      c2x = c.c2x;
      c2y = c.c2y;
      if (c.mode == bof_pkg::MODE_MOVE) begin
        pen_x        = ex;
        pen_y        = ey;
        contour_open = 1'b1;
        return;
      end
      if (c.mode == bof_pkg::MODE_QUAD || c.mode == bof_pkg::MODE_CUBIC) begin
        n = step_count;
        if (n == 0) n = 1;
        if (n > STEP_LIMIT) n = STEP_LIMIT;
        d1 = delta_linear;
        d2 = delta_square;
        d3 = delta_cube;
        if (c.mode == bof_pkg::MODE_QUAD) begin
          ax = 0;
          ay = 0;
          bx = pen_x - 2 * c1x + ex;
          by = pen_y - 2 * c1y + ey;
          cx = 2 * (c1x - pen_x);
          cy = 2 * (c1y - pen_y);
        end else begin
          ax = -pen_x + 3 * c1x - 3 * c2x + ex;
          ay = -pen_y + 3 * c1y - 3 * c2y + ey;
          bx = 3 * pen_x - 6 * c1x + 3 * c2x;
          by = 3 * pen_y - 6 * c1y + 3 * c2y;
          cx = 3 * (c1x - pen_x);
          cy = 3 * (c1y - pen_y);
        end
        fx   = pen_x * q24_one;
        fy   = pen_y * q24_one;
        dfx  = cx * d1 + bx * d2 + ax * d3;
        dfy  = cy * d1 + by * d2 + ay * d3;
        ddx  = 2 * bx * d2 + 6 * ax * d3;
        ddy  = 2 * by * d2 + 6 * ay * d3;
        dddx = 6 * ax * d3;
        dddy = 6 * ay * d3;
        // 64-bit accumulators wrap like the hardware registers
        for (i = 1; i < n; i++) begin
          fx = fx + dfx;
          fy = fy + dfy;
          add_vertex(fx, fy, 1'b0);
          dfx = dfx + ddx;
          dfy = dfy + ddy;
          ddx = ddx + dddx;
          ddy = ddy + dddy;
        end
      end
      add_vertex(ex * q24_one, ey * q24_one, 1'b1);
      pen_x = ex;
      pen_y = ey;
    endfunction

    function void check_vertex(logic signed [bof_pkg::VERT_W-1:0] x,
                               logic signed [bof_pkg::VERT_W-1:0] y,
                               logic [bof_pkg::NUM_W-1:0] number, logic first, logic last);
      vertex_rec_t want;
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex transaction, vertex_number %0d", number);
        errors++;
        return;
      end
      want = expected_vertices.pop_front();
      if (x !== want.x) begin
        $error("vertex_x: expected %0d, actual %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("vertex_y: expected %0d, actual %0d", want.y, y);
        errors++;
      end
      if (number !== want.number) begin
        $error("vertex_number: expected %0d, actual %0d", want.number, number);
        errors++;
      end
      if (first !== want.first) begin
        $error("contour_first: expected %0d, actual %0d", want.first, first);
        errors++;
      end
      if (last !== want.last) begin
        $error("run_last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [IN_DATA_W-1:0]           s_axis_tdata;
  logic [bof_pkg::MODE_W-1:0]     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [bof_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bof_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bof_pkg::CFG_DATA_W-1:0] cfg_data;

  outline_tracker tracker = new();
  bit  quiet;
  bit  long_hold_req;
  bit  long_hold_done;
  int  idle_cycles;
  logic signed [COORD_W-1:0] last_x;
  logic signed [COORD_W-1:0] last_y;

  bezier_outline_flattener #(
    .MAX_STEPS (STEP_LIMIT),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_vertex(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[79:64],
                           m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [bof_pkg::CFG_IDX_W-1:0] index,
                                input logic [bof_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_register(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] steps, input logic [CFG_W-1:0] d1,
                               input logic [CFG_W-1:0] d2, input logic [CFG_W-1:0] d3,
                               input logic [CFG_W-1:0] scale);
    write_register(bof_pkg::REG_STEP_COUNT, steps);
    write_register(bof_pkg::REG_DELTA_LINEAR, d1);
    write_register(bof_pkg::REG_DELTA_SQUARE, d2);
    write_register(bof_pkg::REG_DELTA_CUBE, d3);
    write_register(bof_pkg::REG_OUTPUT_SCALE, scale);
  endtask

  task automatic send_command(input outline_cmd_t c);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.c2y, c.c2x, c.c1y, c.c1x, c.ey, c.ex};
    s_axis_tuser  <= c.mode;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_command(c);
    last_x = c.ex;
    last_y = c.ey;
  endtask

  task automatic send_points(input bof_pkg::mode_t m, input logic signed [COORD_W-1:0] ex,
                             input logic signed [COORD_W-1:0] ey,
                             input logic signed [COORD_W-1:0] c1x,
                             input logic signed [COORD_W-1:0] c1y,
                             input logic signed [COORD_W-1:0] c2x,
                             input logic signed [COORD_W-1:0] c2y);
    outline_cmd_t c;
    c.mode = m;
    c.ex   = ex;
    c.ey   = ey;
    c.c1x  = c1x;
    c.c1y  = c1y;
    c.c2x  = c2x;
    c.c2y  = c2y;
    send_command(c);
  endtask

  // mostly points near the pen, with extremes and full-range values mixed in
  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] near);
    case ($urandom_range(0, 9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return COORD_W'($urandom());
      default: return near + COORD_W'($urandom_range(0, 8191)) - 24'sd4096;
    endcase
  endfunction

  task automatic send_random_command();
    outline_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)      c.mode = bof_pkg::MODE_MOVE;
    else if (pick < 35) c.mode = bof_pkg::MODE_LINE;
    else if (pick < 67) c.mode = bof_pkg::MODE_QUAD;
    else                c.mode = bof_pkg::MODE_CUBIC;
    c.c1x = pick_coord(last_x);
    c.c1y = pick_coord(last_y);
    c.c2x = pick_coord(last_x);
    c.c2y = pick_coord(last_y);
    c.ex  = pick_coord(last_x);
    c.ey  = pick_coord(last_y);
    send_command(c);
  endtask

  // wait out every expected vertex, then the pipeline and any trailing move
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = bof_pkg::MODE_MOVE;
    cfg_valid     = 1'b0;
    cfg_index     = bof_pkg::REG_STEP_COUNT;
    cfg_data      = '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    last_x        = '0;
    last_y        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed commands under the reset settings
    // vertex before any move
    send_points(bof_pkg::MODE_LINE, COORD_MAX, COORD_MIN, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_MOVE, COORD_MIN, COORD_MAX, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_QUAD, '0, '0, COORD_MAX, COORD_MIN, '0, '0);
    send_points(bof_pkg::MODE_CUBIC, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX);
    send_points(bof_pkg::MODE_MOVE, '0, '0, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_MOVE, 24'sd100, -24'sd100, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_LINE, 24'sd64, 24'sd64, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_LINE, -24'sd1, -24'sd1, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_QUAD, 24'sd640, -24'sd320, 24'sd320, 24'sd960, '0, '0);
    send_points(bof_pkg::MODE_CUBIC, -24'sd640, 24'sd200, 24'sd100, -24'sd900,
                -24'sd300, 24'sd700);
    send_points(bof_pkg::MODE_MOVE, -24'sd5000, 24'sd7000, '0, '0, '0, '0);
    send_points(bof_pkg::MODE_CUBIC, 24'sd3000, -24'sd2000, -24'sd4000, 24'sd9000,
                24'sd12000, -24'sd800);
    send_points(bof_pkg::MODE_QUAD, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, '0, '0);
    send_points(bof_pkg::MODE_LINE, '0, COORD_MAX, '0, '0, '0, '0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_setting({18'h2ab55, 7'd1}, 25'd16777216, 25'd16777216, 25'd16777216, 25'd256);
        1: apply_setting({18'h3ffff, 7'd0}, 25'd0, 25'd0, 25'd0, 25'd65535);
        2: apply_setting(25'd64, 25'd262144, 25'd4096, 25'd64, 25'd128);
        3: apply_setting(25'd127, 25'h1ffffff, 25'h1ffffff, 25'h1ffffff, 25'd1);
        4: begin
          write_register(UNUSED_REG, CFG_W'($urandom()));
          apply_setting(25'd65, CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
                        25'd0);
        end
        5: begin
          n = $urandom_range(2, 8);
          apply_setting(CFG_W'(n), CFG_W'(16777216 / n), CFG_W'(16777216 / (n * n)),
                        CFG_W'(16777216 / (n * n * n)), CFG_W'($urandom_range(0, 65535)));
        end
        6: apply_setting(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom()),
                         CFG_W'($urandom()), CFG_W'($urandom()),
                         CFG_W'($urandom_range(0, 65535)));
        default: begin
          quiet = 1'b1;
          apply_setting(25'd16, 25'd1048576, 25'd65536, 25'd4096,
                        CFG_W'($urandom_range(0, 65535)));
        end
      endcase
      // long receiver hold-off while commands keep coming, so the input backs up
      if (phase == 2) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_command();
      drain();
    end

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
